[rtl/pbmi_pkg.sv]
// Shared types and constants for the periodic box minimum-image core.
package pbmi_pkg;

	localparam int BOX_W = 31;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BOX_X = 2'd0,
		CFG_BOX_Y = 2'd1,
		CFG_BOX_Z = 2'd2
	} cfg_idx_t;

	typedef enum logic {
		FUNC_MIN_IMAGE = 1'b0,
		FUNC_WRAP      = 1'b1
	} func_t;

endpackage

[rtl/pbmi_cell.sv]
// One restoring remainder step for one axis: consumes one magnitude bit.
module pbmi_cell #(
	parameter int MAG_W = 33,
	parameter int BIT   = 0
) (
	input  logic                      clk,
	input  logic                      en,
	input  logic [pbmi_pkg::BOX_W-1:0] box,
	input  logic                      neg_i,
	input  logic [MAG_W-1:0]          mag_i,
	input  logic [pbmi_pkg::BOX_W-1:0] rem_i,
	output logic                      neg_q,
	output logic [MAG_W-1:0]          mag_q,
	output logic [pbmi_pkg::BOX_W-1:0] rem_q
);
	import pbmi_pkg::*;

	logic [BOX_W:0] shifted;
	logic [BOX_W:0] diff;

	// rem stays below box, so a set top bit of diff means a borrow
	assign shifted = {rem_i, mag_i[BIT]};
	assign diff    = shifted - {1'b0, box};

	always_ff @(posedge clk) begin
		if (en) begin
			neg_q <= neg_i;
			mag_q <= mag_i;
			rem_q <= diff[BOX_W] ? shifted[BOX_W-1:0] : diff[BOX_W-1:0];
		end
	end

endmodule

[rtl/pbmi_fix.sv]
// Turns a magnitude remainder into the floor remainder, then a saturated image or wrap.
module pbmi_fix #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                       clk,
	input  logic                       en1,
	input  logic                       en2,
	input  logic [pbmi_pkg::BOX_W-1:0] box,
	input  pbmi_pkg::func_t            func,
	input  logic                       neg,
	input  logic [COORD_WIDTH:0]       mag,
	input  logic [pbmi_pkg::BOX_W-1:0] rem,
	output logic [COORD_WIDTH-1:0]     res_s2
);
	import pbmi_pkg::*;

	localparam int DW = COORD_WIDTH + 1;
	localparam int RW = (DW > BOX_W + 2) ? DW : BOX_W + 2;

	func_t            func_s1;
	logic             neg_s1;
	logic [DW-1:0]    mag_s1;
	logic [BOX_W-1:0] r_s1;

	logic [BOX_W:0]   r2;
	logic [RW-1:0]    r_ext;
	logic [RW-1:0]    rmb;
	logic [DW-1:0]    dpass;
	logic [RW-1:0]    full;
	logic             sat_ok;

	always_ff @(posedge clk) begin
		if (en1) begin
			func_s1 <= func;
			neg_s1  <= neg;
			mag_s1  <= mag;
			// negative value with a nonzero remainder: fold back from the box
			r_s1    <= (neg && (rem != '0)) ? box - rem : rem;
		end
	end

	assign r2    = {r_s1, 1'b0};
	assign r_ext = RW'(r_s1);
	assign rmb   = r_ext - RW'(box);
	assign dpass = neg_s1 ? (DW'(0) - mag_s1) : mag_s1;

	always_comb begin
		if (box == '0) begin
			full = RW'($signed(dpass));
		end else if (func_s1 == FUNC_WRAP) begin
			full = r_ext;
		end else if (r2 > {1'b0, box}) begin
			full = rmb;
		end else if (r2 < {1'b0, box}) begin
			full = r_ext;
		end else begin
			// exact half: round the multiple away from zero
			full = neg_s1 ? r_ext : rmb;
		end
	end

	assign sat_ok = (full[RW-1:COORD_WIDTH-1] == '0) || (full[RW-1:COORD_WIDTH-1] == '1);

	always_ff @(posedge clk) begin
		if (en2) begin
			if (sat_ok) begin
				res_s2 <= full[COORD_WIDTH-1:0];
			end else if (full[RW-1]) begin
				res_s2 <= {1'b1, {(COORD_WIDTH-1){1'b0}}};
			end else begin
				res_s2 <= {1'b0, {(COORD_WIDTH-1){1'b1}}};
			end
		end
	end

endmodule

[rtl/periodic_box_minimum_image_core.sv]
// Top level of the periodic box minimum-image and wrap core.
// One item enters per cycle unless the output stalls; in order, two
// input stages form the difference and its magnitude, a row of COORD_WIDTH + 1 remainder
// cells (one magnitude bit each, per axis) reduces it by the box edge, and two stages fold
// the remainder and saturate. Each stage holds while the one after it is full and stalled,
// so bubbles close up behind a waiting result. Box edges reset to 1.0; the user must write
// them only while no item is in flight, as the block itself does not enforce it.
module periodic_box_minimum_image_core #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// first_x, first_y, first_z, second_x, second_y, second_z
	input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]     s_tdata,
	// func
	input  logic                                   s_tuser,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// out_x, out_y, out_z
	output logic [((3*COORD_WIDTH+7)/8)*8-1:0]     m_tdata,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [pbmi_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [pbmi_pkg::BOX_W-1:0]             cfg_data
);
	import pbmi_pkg::*;

	localparam int DW = COORD_WIDTH + 1;
	localparam int L  = DW + 4;
	localparam int OW = ((3*COORD_WIDTH+7)/8)*8;

	logic [BOX_W-1:0] box_q [3];
	logic [L-1:0]     vld_q;
	logic [L-1:0]     rdy;
	func_t            func_q [L];

	logic [DW-1:0]    d_s0 [3];
	logic             neg_c [3][DW+1];
	logic [DW-1:0]    mag_c [3][DW+1];
	logic [BOX_W-1:0] rem_c [3][DW+1];
	logic [COORD_WIDTH-1:0] res [3];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				box_q[k] <= BOX_W'(1) << FRAC_BITS;
			end
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_BOX_X: box_q[0] <= cfg_data;
				CFG_BOX_Y: box_q[1] <= cfg_data;
				CFG_BOX_Z: box_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// a stage takes new data when it is empty or its contents move on
	assign rdy[L-1] = !vld_q[L-1] || m_tready;
	genvar g, a, c;
	generate
		for (g = 0; g < L-1; g++) begin : g_rdy
			assign rdy[g] = !vld_q[g] || rdy[g+1];
		end
	endgenerate
	assign s_tready = rdy[0];
	assign m_tvalid = vld_q[L-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[0]) vld_q[0] <= s_tvalid;
			for (int k = 1; k < L; k++) begin
				if (rdy[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[0]) func_q[0] <= func_t'(s_tuser);
		for (int k = 1; k < L; k++) begin
			if (rdy[k]) func_q[k] <= func_q[k-1];
		end
	end

	generate
		for (a = 0; a < 3; a++) begin : g_axis
			logic signed [COORD_WIDTH-1:0] first;
			logic signed [COORD_WIDTH-1:0] second;
			logic [DW-1:0] fe;
			logic [DW-1:0] se;

			assign first  = s_tdata[a*COORD_WIDTH +: COORD_WIDTH];
			assign second = s_tdata[(a+3)*COORD_WIDTH +: COORD_WIDTH];
			assign fe     = {first[COORD_WIDTH-1], first};
			assign se     = {second[COORD_WIDTH-1], second};

			always_ff @(posedge clk) begin
				if (rdy[0]) d_s0[a] <= (s_tuser == FUNC_WRAP) ? fe : fe - se;
				if (rdy[1]) begin
					neg_c[a][0] <= d_s0[a][DW-1];
					mag_c[a][0] <= d_s0[a][DW-1] ? DW'(0) - d_s0[a] : d_s0[a];
					rem_c[a][0] <= '0;
				end
			end

			for (c = 0; c < DW; c++) begin : g_cell
				pbmi_cell #(.MAG_W(DW), .BIT(DW-1-c)) u_cell (
					.clk  (clk),
					.en   (rdy[2+c]),
					.box  (box_q[a]),
					.neg_i(neg_c[a][c]),
					.mag_i(mag_c[a][c]),
					.rem_i(rem_c[a][c]),
					.neg_q(neg_c[a][c+1]),
					.mag_q(mag_c[a][c+1]),
					.rem_q(rem_c[a][c+1])
				);
			end

			pbmi_fix #(.COORD_WIDTH(COORD_WIDTH)) u_fix (
				.clk   (clk),
				.en1   (rdy[L-2]),
				.en2   (rdy[L-1]),
				.box   (box_q[a]),
				.func  (func_q[L-3]),
				.neg   (neg_c[a][DW]),
				.mag   (mag_c[a][DW]),
				.rem   (rem_c[a][DW]),
				.res_s2(res[a])
			);
		end
	endgenerate

	assign m_tdata = OW'({res[2], res[1], res[0]});

endmodule

[tb/sv/pbmi_checker.sv]
// Checker for the periodic box core: predicts each result and compares it on the output side.
module pbmi_checker
	import pbmi_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [191:0] s_tdata,
	input  logic         s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [95:0]  m_tdata,
	input  logic         cfg_valid,
	input  logic         cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BOX_W-1:0]     cfg_data,
	output int           fail_count,
	output int           pending
);

	logic [BOX_W-1:0] box_edge [3];
	logic [95:0]      image_q [$];

	// One axis: minimum-image difference or floor fold into [0, box), then saturate.
	function automatic logic [31:0] fold_axis(func_t op, logic signed [31:0] a,
			logic signed [31:0] b, logic [BOX_W-1:0] box);
		longint d, bx, r, res;
		bx = box;
		d = (op == FUNC_WRAP) ? a : a - b;
		if (bx == 0) begin
			res = d;
		end else begin
			r = d % bx;
			if (r < 0) r += bx;
			if (op == FUNC_WRAP) res = r;
			else if (2 * r > bx) res = r - bx;
			else if (2 * r < bx) res = r;
			else res = (d > 0) ? r - bx : r;  // exact half: away from zero
		end
		if (res > 64'sh7fffffff) res = 64'sh7fffffff;
		if (res < -64'sh80000000) res = -64'sh80000000;
		return res[31:0];
	endfunction

	assign pending = image_q.size();

	always @(posedge clk or negedge arst_n) begin
		logic [95:0] want;
		func_t       op;
		if (!arst_n) begin
			box_edge[0] = 31'd65536;
			box_edge[1] = 31'd65536;
			box_edge[2] = 31'd65536;
			image_q.delete();
			fail_count = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_BOX_X: box_edge[0] = cfg_data;
					CFG_BOX_Y: box_edge[1] = cfg_data;
					CFG_BOX_Z: box_edge[2] = cfg_data;
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				if (image_q.size() == 0) begin
					$error("unexpected result %h", m_tdata);
					fail_count++;
				end else begin
					want = image_q.pop_front();
					if (m_tdata[31:0] !== want[31:0]) begin
						$error("out_x expected %h got %h", want[31:0], m_tdata[31:0]);
						fail_count++;
					end
					if (m_tdata[63:32] !== want[63:32]) begin
						$error("out_y expected %h got %h", want[63:32], m_tdata[63:32]);
						fail_count++;
					end
					if (m_tdata[95:64] !== want[95:64]) begin
						$error("out_z expected %h got %h", want[95:64], m_tdata[95:64]);
						fail_count++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				op = func_t'(s_tuser);
				for (int k = 0; k < 3; k++)
					want[32*k +: 32] = fold_axis(op, s_tdata[32*k +: 32],
						s_tdata[96 + 32*k +: 32], box_edge[k]);
				image_q.push_back(want);
			end
		end
	end

endmodule

[tb/sv/tb.sv]
// Testbench top: stimulus, box settings and verdict for the periodic box core.
module tb;
	import pbmi_pkg::*;

	localparam int DRAIN = 45;
	localparam int STALL_LIMIT = 4000;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [191:0] s_tdata;   // first_x, first_y, first_z, second_x, second_y, second_z
	logic         s_tuser;   // func
	logic         m_tvalid;
	logic         m_tready;
	logic [95:0]  m_tdata;   // out_x, out_y, out_z
	logic         cfg_valid;
	logic         cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [BOX_W-1:0]     cfg_data;
	int           fail_count;
	int           pending;
	int           idle_cycles;
	int           stall_left;
	bit           calm;
	logic [BOX_W-1:0] cur_box;

	periodic_box_minimum_image_core u_top (.*);

	pbmi_checker u_chk (.*);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Receiver back-pressure: short stalls mostly, a few long, and calm stretches.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left <= 0;
			calm <= 1'b0;
		end else begin
			if ($urandom_range(0, 199) == 0) calm <= ~calm;
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left <= stall_left - 1;
			end else begin
				m_tready <= 1'b1;
				if (!calm && $urandom_range(0, 3) == 0)
					stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60)
						: $urandom_range(1, 3);
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic int pick_gap();
		if ($urandom_range(0, 39) == 0) return $urandom_range(20, 60);
		if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
		return 0;
	endfunction

	task automatic send_item(func_t op, logic [31:0] c [6], int gap);
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {c[5], c[4], c[3], c[2], c[1], c[0]};
		do @(posedge clk); while (!s_tready);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Hold until every expected result is out and the pipeline has emptied.
	task automatic drain();
		while (pending != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	// Leave valid high; the caller drops it after the last write of a burst.
	task automatic write_box(cfg_idx_t idx, logic [BOX_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Random coordinate pair: mostly near a half box apart, some wide random, some extremes.
	task automatic random_pair(output logic [31:0] a, output logic [31:0] b);
		longint d;
		b = $urandom;
		case ($urandom_range(0, 9))
			0, 1, 2: a = $urandom;
			3: begin
				a = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
				b = $urandom_range(0, 2) == 0 ? $urandom
					: ($urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000);
			end
			default: begin
				d = longint'($urandom_range(0, 6)) - 3;
				d = d * cur_box + cur_box / 2 + (longint'($urandom_range(0, 4)) - 2);
				a = b + d[31:0];
			end
		endcase
	endtask

	task automatic run_phase(int n);
		logic [31:0] c [6];
		func_t op;
		for (int i = 0; i < n; i++) begin
			op = ($urandom_range(0, 2) == 0) ? FUNC_WRAP : FUNC_MIN_IMAGE;
			for (int k = 0; k < 3; k++) random_pair(c[k], c[k+3]);
			send_item(op, c, (i == n - 1) ? 1 : pick_gap());
		end
	endtask

	task automatic set_boxes(logic [BOX_W-1:0] bx, logic [BOX_W-1:0] by, logic [BOX_W-1:0] bz);
		drain();
		write_box(CFG_BOX_X, bx);
		write_box(CFG_BOX_Y, by);
		write_box(CFG_BOX_Z, bz);
		cfg_valid <= 1'b0;
		cur_box = bx;
	endtask

	initial begin
		logic [31:0] c [6];
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		idle_cycles = 0;
		cur_box = 31'd65536;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, both operations, exact halves either side, at the reset box.
		c = '{32'h7fffffff, 32'h80000000, 32'h0, 32'h80000000, 32'h7fffffff, 32'hffffffff};
		send_item(FUNC_MIN_IMAGE, c, 0);
		send_item(FUNC_WRAP, c, 0);
		c = '{32'h00008000, 32'hffff8000, 32'h00018000, 32'h0, 32'h0, 32'h0};
		send_item(FUNC_MIN_IMAGE, c, 0);
		send_item(FUNC_WRAP, c, 0);
		c = '{32'h0, 32'h0, 32'h0, 32'h00008000, 32'hffff8000, 32'h00010000};
		send_item(FUNC_MIN_IMAGE, c, 2);
		c = '{32'hffffffff, 32'h00010000, 32'hfffeffff, 32'h7fffffff, 32'h0, 32'h80000000};
		send_item(FUNC_WRAP, c, 0);
		send_item(FUNC_MIN_IMAGE, c, 1);
		run_phase(190);

		set_boxes(31'd1, 31'd1, 31'd1);
		run_phase(150);
		set_boxes(31'h7fffffff, 31'h7fffffff, 31'h7fffffff);
		c = '{32'h7fffffff, 32'h80000000, 32'hc0000000, 32'h80000000, 32'h7fffffff, 32'h3fffffff};
		send_item(FUNC_MIN_IMAGE, c, 0);
		send_item(FUNC_WRAP, c, 1);
		run_phase(180);
		// Zero edge: no reduction, differences saturate.
		set_boxes(31'd0, 31'd2, 31'd0);
		c = '{32'h7fffffff, 32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h1};
		send_item(FUNC_MIN_IMAGE, c, 0);
		send_item(FUNC_WRAP, c, 1);
		run_phase(150);
		set_boxes(31'd4, 31'd3, 31'h40000000);
		run_phase(180);
		for (int p = 0; p < 4; p++) begin
			if (p[0])
				set_boxes(BOX_W'($urandom_range(1, 1000)), BOX_W'($urandom_range(1, 1000)),
					BOX_W'($urandom));
			else
				set_boxes(BOX_W'($urandom), BOX_W'($urandom_range(1, 1 << 20)),
					BOX_W'($urandom_range(1, 1 << 18)));
			run_phase(140);
		end

		drain();
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
